// ----- src/rb2d_pkg.sv -----
// Shared definitions for the 2D rigid body step block.
// Default widths, register reset values, register indexes and shared unit control.
`timescale 1ns / 1ps

package rb2d_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int DT_BITS        = 16;

  localparam logic signed [63:0] MASS_RST = 64'sd65536;
  localparam logic signed [63:0] GX_RST   = 64'sd0;
  localparam logic signed [63:0] GY_RST   = 64'sd85196800;
  localparam logic signed [63:0] SIDE_RST = 64'sd13107200;
  localparam logic signed [63:0] FALL_RST = 64'sd52428800;
  localparam logic signed [63:0] FRIC_RST = 64'sd3276800;
  localparam logic [15:0]        DT_RST   = 16'd1092;

  localparam logic [2:0] REG_BODY_MASS  = 3'd0;
  localparam logic [2:0] REG_GRAVITY_X  = 3'd1;
  localparam logic [2:0] REG_GRAVITY_Y  = 3'd2;
  localparam logic [2:0] REG_SIDE_LIMIT = 3'd3;
  localparam logic [2:0] REG_FALL_LIMIT = 3'd4;
  localparam logic [2:0] REG_FRICTION   = 3'd5;
  localparam logic [2:0] REG_FRAME_TIME = 3'd6;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_MULDIV,
    ALU_SQRT,
    ALU_MULSH
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

endpackage

// ----- src/rb2d_alu.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, square root.
// Depends on rb2d_pkg for the operation codes and the control struct.
`timescale 1ns / 1ps

module rb2d_alu #(
  parameter int W   = rb2d_pkg::WORD_WIDTH_DEF,
  parameter int OPW = rb2d_pkg::WORD_WIDTH_DEF + 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rb2d_pkg::alu_ctl_t    ctl,
  input  logic signed [OPW:0]   a,
  input  logic signed [OPW:0]   b,
  input  logic [OPW-1:0]        c,
  input  logic [7:0]            sh,
  input  logic [2*OPW-1:0]      wide_in,
  output logic                  done,
  output logic [2*OPW-1:0]      res_wide,
  output logic signed [W-1:0]   res_word
);

  localparam int CW = $clog2(2 * OPW);
  localparam logic [2*OPW-1:0] QMAX = {{(2*OPW-W+1){1'b0}}, {(W-1){1'b1}}};

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_SQRT} phase_t;

  phase_t              phase;
  rb2d_pkg::alu_op_t   op;
  logic                neg;
  logic [CW-1:0]       cnt;
  logic [2*OPW-1:0]    acc;
  logic [2*OPW-1:0]    mcand;
  logic [OPW-1:0]      mpl;
  logic [OPW-1:0]      dvs;
  logic [7:0]          shamt;
  logic [OPW+1:0]      rem;
  logic [OPW-1:0]      root;

  logic [OPW:0]        a_abs;
  logic [OPW:0]        b_abs;
  logic [2*OPW-1:0]    mul_next;
  logic [OPW+1:0]      div_sh;
  logic                div_bit;
  logic [OPW+1:0]      div_rem_next;
  logic [2*OPW-1:0]    div_acc_next;
  logic [OPW+3:0]      sq_sh;
  logic [OPW+3:0]      sq_trial;
  logic                sq_bit;
  logic [OPW+1:0]      sq_rem_next;
  logic [OPW-1:0]      sq_root_next;
  logic [2*OPW-1:0]    quo;
  logic signed [W-1:0] q_sat;
  logic                done_next;

  always_comb begin
    a_abs = a[OPW] ? -a : a;
    b_abs = b[OPW] ? -b : b;
    mul_next = mpl[0] ? acc + mcand : acc;
    div_sh = {rem[OPW:0], acc[2*OPW-1]};
    div_bit = div_sh >= {2'b00, dvs};
    div_rem_next = div_bit ? div_sh - {2'b00, dvs} : div_sh;
    div_acc_next = {acc[2*OPW-2:0], div_bit};
    sq_sh = {rem, acc[2*OPW-1:2*OPW-2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_bit = sq_sh >= sq_trial;
    sq_rem_next = sq_bit ? sq_sh[OPW+1:0] - sq_trial[OPW+1:0] : sq_sh[OPW+1:0];
    sq_root_next = {root[OPW-2:0], sq_bit};
    quo = (phase == A_DIV) ? div_acc_next : (mul_next >> shamt);
    if (neg) begin
      if (quo > QMAX + 1'b1) begin
        q_sat = {1'b1, {(W-1){1'b0}}};
      end else begin
        q_sat = -quo[W-1:0];
      end
    end else begin
      if (quo > QMAX) begin
        q_sat = {1'b0, {(W-1){1'b1}}};
      end else begin
        q_sat = quo[W-1:0];
      end
    end
    done_next = ((phase == A_MUL) && (cnt == CW'(OPW - 1)) && (op != rb2d_pkg::ALU_MULDIV))
             || ((phase == A_DIV) && (cnt == CW'(2 * OPW - 1)))
             || ((phase == A_SQRT) && (cnt == CW'(OPW - 1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= A_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= done_next;
      case (phase)
        A_IDLE: begin
          if (ctl.start) begin
            op    <= ctl.op;
            neg   <= a[OPW] ^ b[OPW];
            dvs   <= c;
            shamt <= sh;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            if (ctl.op == rb2d_pkg::ALU_SQRT) begin
              acc   <= wide_in;
              phase <= A_SQRT;
            end else begin
              acc   <= '0;
              mcand <= {{OPW{1'b0}}, b_abs[OPW-1:0]};
              mpl   <= a_abs[OPW-1:0];
              phase <= A_MUL;
            end
          end
        end
        A_MUL: begin
          acc   <= mul_next;
          mcand <= {mcand[2*OPW-2:0], 1'b0};
          mpl   <= {1'b0, mpl[OPW-1:1]};
          if (cnt == CW'(OPW - 1)) begin
            cnt <= '0;
            if (op == rb2d_pkg::ALU_MUL) begin
              res_wide <= mul_next;
              phase    <= A_IDLE;
            end else if (op == rb2d_pkg::ALU_MULSH) begin
              res_word <= q_sat;
              phase    <= A_IDLE;
            end else begin
              phase <= A_DIV;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        A_DIV: begin
          acc <= div_acc_next;
          rem <= div_rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(2 * OPW - 1)) begin
            res_word <= q_sat;
            phase    <= A_IDLE;
          end
        end
        A_SQRT: begin
          acc  <= {acc[2*OPW-3:0], 2'b00};
          rem  <= sq_rem_next;
          root <= sq_root_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(OPW - 1)) begin
            res_wide <= {{OPW{1'b0}}, sq_root_next};
            phase    <= A_IDLE;
          end
        end
        default: phase <= A_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rigid_body_2d_step.sv -----
// Top level of the 2D rigid body step: stream ports, registers, sequencer, result register.
// Depends on rb2d_pkg and rb2d_alu.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata fx,fy,pos_x,pos_y; tuser on_ground
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata new_pos_x,new_pos_y,vel_x,vel_y
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item runs through the shared unit: OPW = WORD_WIDTH+16. An item uses up to 10 divides,
// 12 scaled products and 4 lengths. The velocity resets to zero and the registers to their
// defaults. s_axis_tready is high only while the sequencer is idle; a result held by
// m_axis_tready stays in its register while the next item is taken.
`timescale 1ns / 1ps

module rigid_body_2d_step #(
  parameter int FRAC_BITS  = rb2d_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = rb2d_pkg::WORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // force_x, force_y, pos_x, pos_y
  input  logic [0:0]   s_axis_tuser,   // on_ground
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // new_pos_x, new_pos_y, vel_x_out, vel_y_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int W   = WORD_WIDTH;
  localparam int OPW = WORD_WIDTH + 16;
  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam logic [OPW-1:0] ONE_F = {{(OPW-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_FVX, S_FVY, S_LSQX, S_LSQY, S_LSQRT, S_GUX, S_GUY, S_GRX, S_GRY,
    S_PD1, S_PD2, S_PPX, S_PPY, S_PSUB, S_CMX, S_CMY, S_SUM, S_FT1, S_FT2,
    S_FCMP, S_FMX, S_FMY, S_OUTX, S_OUTY, S_DONE
  } st_t;

  typedef enum logic [1:0] {L_G, L_P, L_S, L_V} lsel_t;

  function automatic logic signed [63:0] ext64(input logic signed [W-1:0] x);
    ext64 = {{(64-W){x[W-1]}}, x};
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] x);
    if (x > WMAX64) begin
      sat_w = WMAX64[W-1:0];
    end else if (x < WMIN64) begin
      sat_w = WMIN64[W-1:0];
    end else begin
      sat_w = x[W-1:0];
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [W-1:0] x);
    logic signed [63:0] v;
    v = ext64(x);
    if (v > 64'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [OPW:0] exto(input logic signed [W-1:0] x);
    exto = {{(OPW+1-W){x[W-1]}}, x};
  endfunction

  logic signed [W-1:0] mass, gx, gy, side_lim, fall_lim, fric;
  logic [15:0]         dt;

  st_t                 state;
  lsel_t               lsel;
  logic                issued, grd, gz, pass;
  logic signed [W-1:0] vx, vy, fx, fy, x_in, y_in;
  logic signed [W-1:0] ux, uy, dot1, dot, px, py, sx, sy, tf, fm, ox, oy;
  logic [OPW-1:0]      gl, len;
  logic [2*OPW-1:0]    acc;

  rb2d_pkg::alu_ctl_t  ctl;
  logic signed [OPW:0] op_a, op_b;
  logic [OPW-1:0]      op_c;
  logic [7:0]          op_sh;
  logic                alu_state, alu_done;
  logic [2*OPW-1:0]    res_wide;
  logic signed [W-1:0] res_word;
  logic signed [W-1:0] m_eff, lsx, lsy, lim;
  logic [OPW-1:0]      root;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mass     <= sat_w(rb2d_pkg::MASS_RST);
      gx       <= sat_w(rb2d_pkg::GX_RST);
      gy       <= sat_w(rb2d_pkg::GY_RST);
      side_lim <= sat_w(rb2d_pkg::SIDE_RST);
      fall_lim <= sat_w(rb2d_pkg::FALL_RST);
      fric     <= sat_w(rb2d_pkg::FRIC_RST);
      dt       <= rb2d_pkg::DT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rb2d_pkg::REG_BODY_MASS:  mass     <= sat_w({33'd0, cfg_data[30:0]});
        rb2d_pkg::REG_GRAVITY_X:  gx       <= sat_w({{32{cfg_data[31]}}, cfg_data});
        rb2d_pkg::REG_GRAVITY_Y:  gy       <= sat_w({{32{cfg_data[31]}}, cfg_data});
        rb2d_pkg::REG_SIDE_LIMIT: side_lim <= sat_w({33'd0, cfg_data[30:0]});
        rb2d_pkg::REG_FALL_LIMIT: fall_lim <= sat_w({33'd0, cfg_data[30:0]});
        rb2d_pkg::REG_FRICTION:   fric     <= sat_w({33'd0, cfg_data[30:0]});
        rb2d_pkg::REG_FRAME_TIME: dt       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m_eff = (mass == '0) ? {{(W-1){1'b0}}, 1'b1} : mass;
    case (lsel)
      L_G: begin lsx = gx; lsy = gy; end
      L_P: begin lsx = px; lsy = py; end
      L_S: begin lsx = sx; lsy = sy; end
      default: begin lsx = vx; lsy = vy; end
    endcase
    lim  = (lsel == L_P) ? fall_lim : side_lim;
    root = res_wide[OPW-1:0];
    alu_state = 1'b1;
    ctl.op = rb2d_pkg::ALU_MULDIV;
    op_a = '0;
    op_b = '0;
    op_c = ONE_F;
    op_sh = 8'(FRAC_BITS);
    case (state)
      S_FVX: begin
        op_a = exto(fx); op_b = {1'b0, {{(OPW-16){1'b0}}, dt} << FRAC_BITS};
        op_c = {{(OPW-W){1'b0}}, m_eff} << rb2d_pkg::DT_BITS;
      end
      S_FVY: begin
        op_a = exto(fy); op_b = {1'b0, {{(OPW-16){1'b0}}, dt} << FRAC_BITS};
        op_c = {{(OPW-W){1'b0}}, m_eff} << rb2d_pkg::DT_BITS;
      end
      S_LSQX:  begin ctl.op = rb2d_pkg::ALU_MUL; op_a = exto(lsx); op_b = exto(lsx); end
      S_LSQY:  begin ctl.op = rb2d_pkg::ALU_MUL; op_a = exto(lsy); op_b = exto(lsy); end
      S_LSQRT: ctl.op = rb2d_pkg::ALU_SQRT;
      S_GUX:   begin op_a = exto(gx); op_b = {1'b0, ONE_F}; op_c = gl; end
      S_GUY:   begin op_a = exto(gy); op_b = {1'b0, ONE_F}; op_c = gl; end
      S_GRX: begin
        ctl.op = rb2d_pkg::ALU_MULSH; op_sh = 8'(rb2d_pkg::DT_BITS);
        op_a = exto(gx); op_b = {{(OPW-15){1'b0}}, dt};
      end
      S_GRY: begin
        ctl.op = rb2d_pkg::ALU_MULSH; op_sh = 8'(rb2d_pkg::DT_BITS);
        op_a = exto(gy); op_b = {{(OPW-15){1'b0}}, dt};
      end
      S_PD1:   begin ctl.op = rb2d_pkg::ALU_MULSH; op_a = exto(vx); op_b = exto(ux); end
      S_PD2:   begin ctl.op = rb2d_pkg::ALU_MULSH; op_a = exto(vy); op_b = exto(uy); end
      S_PPX:   begin ctl.op = rb2d_pkg::ALU_MULSH; op_a = exto(ux); op_b = exto(dot); end
      S_PPY:   begin ctl.op = rb2d_pkg::ALU_MULSH; op_a = exto(uy); op_b = exto(dot); end
      S_CMX:   begin op_a = exto(lsx); op_b = exto(lim); op_c = len; end
      S_CMY:   begin op_a = exto(lsy); op_b = exto(lim); op_c = len; end
      S_FT1:   begin ctl.op = rb2d_pkg::ALU_MULSH; op_a = exto(fric); op_b = exto(m_eff); end
      S_FT2: begin
        ctl.op = rb2d_pkg::ALU_MULSH; op_sh = 8'(rb2d_pkg::DT_BITS);
        op_a = exto(tf); op_b = {{(OPW-15){1'b0}}, dt};
      end
      S_FMX:   begin op_a = exto(vx); op_b = exto(fm); op_c = len; end
      S_FMY:   begin op_a = exto(vy); op_b = exto(fm); op_c = len; end
      S_OUTX: begin
        ctl.op = rb2d_pkg::ALU_MULSH; op_sh = 8'(rb2d_pkg::DT_BITS);
        op_a = exto(vx); op_b = {{(OPW-15){1'b0}}, dt};
      end
      S_OUTY: begin
        ctl.op = rb2d_pkg::ALU_MULSH; op_sh = 8'(rb2d_pkg::DT_BITS);
        op_a = exto(vy); op_b = {{(OPW-15){1'b0}}, dt};
      end
      default: alu_state = 1'b0;
    endcase
    ctl.start = alu_state && !issued;
  end

  rb2d_alu #(.W(W), .OPW(OPW)) u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .a        (op_a),
    .b        (op_b),
    .c        (op_c),
    .sh       (op_sh),
    .wide_in  (acc),
    .done     (alu_done),
    .res_wide (res_wide),
    .res_word (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      vx            <= '0;
      vy            <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ctl.start) begin
        issued <= 1'b1;
      end
      if (alu_done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            fx    <= sat_w({{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]});
            fy    <= sat_w({{32{s_axis_tdata[63]}}, s_axis_tdata[63:32]});
            x_in  <= sat_w({{32{s_axis_tdata[95]}}, s_axis_tdata[95:64]});
            y_in  <= sat_w({{32{s_axis_tdata[127]}}, s_axis_tdata[127:96]});
            grd   <= s_axis_tuser[0];
            pass  <= 1'b0;
            state <= S_FVX;
          end
        end
        S_FVX: if (alu_done) begin
          vx <= sat_w(ext64(vx) + ext64(res_word)); state <= S_FVY;
        end
        S_FVY: if (alu_done) begin
          vy <= sat_w(ext64(vy) + ext64(res_word)); lsel <= L_G; state <= S_LSQX;
        end
        S_LSQX: if (alu_done) begin
          acc <= res_wide; state <= S_LSQY;
        end
        S_LSQY: if (alu_done) begin
          acc <= acc + res_wide; state <= S_LSQRT;
        end
        S_LSQRT: if (alu_done) begin
          len <= root;
          case (lsel)
            L_G: begin
              gl <= root;
              gz <= (root == '0);
              if (root != '0) begin
                state <= S_GUX;
              end else if (grd) begin
                px <= '0; py <= '0; state <= S_PSUB;
              end else begin
                state <= S_GRX;
              end
            end
            L_P: begin
              if ({{(OPW-W){1'b0}}, fall_lim} < root) begin
                state <= S_CMX;
              end else begin
                lsel <= L_S; state <= S_LSQX;
              end
            end
            L_S: begin
              state <= ({{(OPW-W){1'b0}}, side_lim} < root) ? S_CMX : S_SUM;
            end
            default: state <= S_FT1;
          endcase
        end
        S_GUX: if (alu_done) begin
          ux <= res_word; state <= S_GUY;
        end
        S_GUY: if (alu_done) begin
          uy <= res_word; state <= grd ? S_PD1 : S_GRX;
        end
        S_GRX: if (alu_done) begin
          vx <= sat_w(ext64(vx) + ext64(res_word)); state <= S_GRY;
        end
        S_GRY: if (alu_done) begin
          vy   <= sat_w(ext64(vy) + ext64(res_word));
          pass <= 1'b1;
          if (gz) begin
            px <= '0; py <= '0; state <= S_PSUB;
          end else begin
            state <= S_PD1;
          end
        end
        S_PD1: if (alu_done) begin
          dot1 <= res_word; state <= S_PD2;
        end
        S_PD2: if (alu_done) begin
          dot <= sat_w(ext64(dot1) + ext64(res_word)); state <= S_PPX;
        end
        S_PPX: if (alu_done) begin
          px <= res_word; state <= S_PPY;
        end
        S_PPY: if (alu_done) begin
          py <= res_word; state <= S_PSUB;
        end
        S_PSUB: begin
          if (!pass) begin
            vx   <= sat_w(ext64(vx) - ext64(px));
            vy   <= sat_w(ext64(vy) - ext64(py));
            pass <= 1'b1;
            if (gz) begin
              px <= '0; py <= '0;
            end else begin
              state <= S_PD1;
            end
          end else begin
            sx    <= sat_w(ext64(vx) - ext64(px));
            sy    <= sat_w(ext64(vy) - ext64(py));
            lsel  <= L_P;
            state <= S_LSQX;
          end
        end
        S_CMX: if (alu_done) begin
          if (lsel == L_P) begin
            px <= res_word;
          end else begin
            sx <= res_word;
          end
          state <= S_CMY;
        end
        S_CMY: if (alu_done) begin
          if (lsel == L_P) begin
            py <= res_word; lsel <= L_S; state <= S_LSQX;
          end else begin
            sy <= res_word; state <= S_SUM;
          end
        end
        S_SUM: begin
          vx <= sat_w(ext64(px) + ext64(sx));
          vy <= sat_w(ext64(py) + ext64(sy));
          if (sat_w(ext64(px) + ext64(sx)) == '0 && sat_w(ext64(py) + ext64(sy)) == '0) begin
            state <= S_OUTX;
          end else begin
            lsel <= L_V; state <= S_LSQX;
          end
        end
        S_FT1: if (alu_done) begin
          tf <= res_word; state <= S_FT2;
        end
        S_FT2: if (alu_done) begin
          fm <= res_word; state <= S_FCMP;
        end
        S_FCMP: begin
          if (len < {{(OPW-W){1'b0}}, fm}) begin
            vx <= '0; vy <= '0; state <= S_OUTX;
          end else begin
            state <= S_FMX;
          end
        end
        S_FMX: if (alu_done) begin
          vx <= sat_w(ext64(vx) - ext64(res_word)); state <= S_FMY;
        end
        S_FMY: if (alu_done) begin
          vy <= sat_w(ext64(vy) - ext64(res_word)); state <= S_OUTX;
        end
        S_OUTX: if (alu_done) begin
          ox <= sat_w(ext64(x_in) + ext64(res_word)); state <= S_OUTY;
        end
        S_OUTY: if (alu_done) begin
          oy <= sat_w(ext64(y_in) - ext64(res_word)); state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {sat32(vy), sat32(vx), sat32(oy), sat32(ox)};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
